/* hw/rtl/tag_value_field_parser_top_macros.svh */
// assertion helpers for the tag-value field parser
// each macro expects signals named clk and rst_n in the calling scope
`ifndef TAG_VALUE_FIELD_PARSER_TOP_MACROS_SVH
`define TAG_VALUE_FIELD_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define TVFP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvfp assertion failed");

// next-cycle implication
`define TVFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvfp assertion failed");

`endif

/* hw/rtl/tvfp_pkg.sv */
`timescale 1ns / 1ps

package tvfp_pkg;

  // parse phases
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_PROTO   = 3'd1;
  localparam logic [2:0] PH_KEY_HI  = 3'd2;
  localparam logic [2:0] PH_KEY_LO  = 3'd3;
  localparam logic [2:0] PH_WAIT_EQ = 3'd4;
  localparam logic [2:0] PH_VALUE   = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_CHAR    = 3'd0;
  localparam logic [2:0] KIND_NEW_MSG = 3'd1;
  localparam logic [2:0] KIND_FIELD   = 3'd2;
  localparam logic [2:0] KIND_END     = 3'd3;
  localparam logic [2:0] KIND_ERROR   = 3'd4;

  // framing characters
  localparam logic [7:0] CH_END = 8'h7E;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_BAR = 8'h7C;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_BYTE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_KEY      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE_LEN = 2'd3;

  // configuration reset values
  localparam logic [7:0]  RST_START_BYTE    = 8'd1;
  localparam logic [7:0]  RST_PROTOCOL_BYTE = 8'd1;
  localparam logic [15:0] RST_TYPE_KEY      = 16'd19780;
  localparam logic [7:0]  RST_MAX_VALUE_LEN = 8'd39;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  protocol_byte;
    logic [15:0] type_key;
    logic [7:0]  max_value_len;
  } tvfp_cfg_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] key;
    logic [15:0] msg_type;
    logic [7:0]  data;
    logic [7:0]  value_len;
  } tvfp_res_t;

endpackage

/* hw/rtl/tvfp_if.sv */
`timescale 1ns / 1ps

// received byte channel
interface tvfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// parse result channel
interface tvfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] key;
  logic [15:0] msg_type;
  logic [7:0]  data;
  logic [7:0]  value_len;

  modport source (output valid, output kind, output key, output msg_type,
                  output data, output value_len, input ready);
  modport sink (input valid, input kind, input key, input msg_type,
                input data, input value_len, output ready);
endinterface

/* hw/rtl/tvfp_parser.sv */
`timescale 1ns / 1ps

module tvfp_parser import tvfp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] rx_byte,
  input  tvfp_cfg_t  cfg,
  output logic       res_valid,
  output tvfp_res_t  res
);

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] key_r, key_nxt;
  logic [15:0] type_r, type_nxt;
  logic        type_known_r, type_known_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] ftc_r, ftc_nxt;
  logic        err;
  logic [15:0] cur_type;

  assign cur_type = type_known_r ? type_r : 16'd0;

  always_comb begin
    phase_nxt      = phase_r;
    key_nxt        = key_r;
    type_nxt       = type_r;
    type_known_nxt = type_known_r;
    len_nxt        = len_r;
    ftc_nxt        = ftc_r;
    err            = 1'b0;
    res_valid      = 1'b0;
    res            = '0;
    res.msg_type   = cur_type;
    res.key        = key_r;

    case (phase_r)
      PH_PROTO: begin
        if (rx_byte != cfg.protocol_byte) err = 1'b1;
        else phase_nxt = PH_KEY_HI;
      end
      PH_KEY_HI: begin
        if (rx_byte == CH_END) begin
          res_valid      = 1'b1;
          res.kind       = KIND_END;
          res.key        = 16'd0;
          type_known_nxt = 1'b0;
          type_nxt       = 16'd0;
          key_nxt        = 16'd0;
          len_nxt        = 8'd0;
          phase_nxt      = PH_HUNT;
        end else begin
          key_nxt   = {rx_byte, 8'd0};
          phase_nxt = PH_KEY_LO;
        end
      end
      PH_KEY_LO: begin
        key_nxt   = {key_r[15:8], rx_byte};
        phase_nxt = PH_WAIT_EQ;
      end
      PH_WAIT_EQ: begin
        if (rx_byte != CH_EQ) begin
          err = 1'b1;
        end else begin
          len_nxt   = 8'd0;
          ftc_nxt   = 16'd0;
          phase_nxt = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (rx_byte == CH_BAR) begin
          if (!type_known_r && key_r != cfg.type_key) begin
            err = 1'b1;
          end else begin
            res_valid     = 1'b1;
            res.value_len = len_r;
            if (key_r == cfg.type_key) begin
              type_nxt       = ftc_r;
              type_known_nxt = 1'b1;
              res.kind       = KIND_NEW_MSG;
              res.msg_type   = ftc_r;
            end else begin
              res.kind = KIND_FIELD;
            end
            len_nxt   = 8'd0;
            phase_nxt = PH_KEY_HI;
          end
        end else if (len_r >= cfg.max_value_len) begin
          err = 1'b1;
        end else begin
          if (len_r == 8'd0) ftc_nxt = {rx_byte, 8'd0};
          else if (len_r == 8'd1) ftc_nxt = {ftc_r[15:8], rx_byte};
          len_nxt       = len_r + 8'd1;
          res_valid     = 1'b1;
          res.kind      = KIND_CHAR;
          res.data      = rx_byte;
          res.value_len = len_r + 8'd1;
        end
      end
      default: begin
        // hunting, undefined codes included
        if (rx_byte == cfg.start_byte) begin
          key_nxt        = 16'd0;
          type_nxt       = 16'd0;
          type_known_nxt = 1'b0;
          len_nxt        = 8'd0;
          phase_nxt      = PH_PROTO;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
    endcase

    if (err) begin
      res_valid      = 1'b1;
      res.kind       = KIND_ERROR;
      res.key        = key_r;
      res.msg_type   = cur_type;
      res.data       = 8'd0;
      res.value_len  = len_r;
      type_known_nxt = 1'b0;
      type_nxt       = 16'd0;
      key_nxt        = 16'd0;
      len_nxt        = 8'd0;
      phase_nxt      = PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HUNT;
      key_r        <= 16'd0;
      type_r       <= 16'd0;
      type_known_r <= 1'b0;
      len_r        <= 8'd0;
      ftc_r        <= 16'd0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      key_r        <= key_nxt;
      type_r       <= type_nxt;
      type_known_r <= type_known_nxt;
      len_r        <= len_nxt;
      ftc_r        <= ftc_nxt;
    end
  end

endmodule

/* hw/rtl/tag_value_field_parser_top.sv */
`timescale 1ns / 1ps

// channel  | dir | payload                                  | handshake
// in_ch    | in  | rx_byte[7:0]                             | valid/ready
// out_ch   | out | kind, key, msg_type, data, value_len     | valid/ready
// cfg      | in  | cfg_index[1:0], cfg_data[15:0]           | cfg_we, no wait
//
// one byte per clock sustained while out_ch is not stalled; a byte's result
// passes through the input byte register and then the result register
// bytes that cause no result still pass through the parse step in order
// rst_n is synchronous: parser back to hunting, registers to their defaults
// a stalled out_ch holds its result; the input register keeps taking a byte
// while the parse step can advance, and stalls once it is full and blocked
module tag_value_field_parser_top import tvfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tvfp_in_if.sink               in_ch,
  tvfp_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  tvfp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= RST_START_BYTE;
      cfg_r.protocol_byte <= RST_PROTOCOL_BYTE;
      cfg_r.type_key      <= RST_TYPE_KEY;
      cfg_r.max_value_len <= RST_MAX_VALUE_LEN;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_BYTE:    cfg_r.start_byte    <= cfg_data[7:0];
        CFG_PROTOCOL_BYTE: cfg_r.protocol_byte <= cfg_data[7:0];
        CFG_TYPE_KEY:      cfg_r.type_key      <= cfg_data[15:0];
        CFG_MAX_VALUE_LEN: cfg_r.max_value_len <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // input byte register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       step_en;
  logic       in_take;

  // the parse step advances when a byte is held and the result slot frees up
  assign step_en     = in_valid_r && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step_en;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (step_en) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // parse state and next-state logic
  logic      res_valid;
  tvfp_res_t res;

  tvfp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .rx_byte   (in_byte_r),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register
  logic      out_valid_r;
  tvfp_res_t out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.kind      = out_res_r.kind;
  assign out_ch.key       = out_res_r.key;
  assign out_ch.msg_type  = out_res_r.msg_type;
  assign out_ch.data      = out_res_r.data;
  assign out_ch.value_len = out_res_r.value_len;

endmodule

/* hw/rtl/tvfp_checker.sv */
`timescale 1ns / 1ps

`include "tag_value_field_parser_top_macros.svh"

module tvfp_checker import tvfp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_kind,
  input logic [15:0] out_key,
  input logic [15:0] out_msg_type,
  input logic [7:0]  out_data,
  input logic [7:0]  out_value_len
);

  // a stalled result stays put
  `TVFP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_key) && $stable(out_msg_type) && $stable(out_data) && $stable(out_value_len))

  // only value characters carry data
  `TVFP_ASSERT_NOW(a_data_only_char, out_valid && out_kind != KIND_CHAR, out_data == 8'd0)

  // end of message reports no key and no length
  `TVFP_ASSERT_NOW(a_end_clean, out_valid && out_kind == KIND_END, out_key == 16'd0 && out_value_len == 8'd0)

  // a value character always counts itself
  `TVFP_ASSERT_NOW(a_char_len, out_valid && out_kind == KIND_CHAR, out_value_len != 8'd0)

endmodule

bind tag_value_field_parser_top tvfp_checker u_tvfp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_kind      (out_ch.kind),
  .out_key       (out_ch.key),
  .out_msg_type  (out_ch.msg_type),
  .out_data      (out_ch.data),
  .out_value_len (out_ch.value_len)
);

/* sim/tb_tag_value_field_parser_top.sv */
`timescale 1ns / 1ps

// byte-level check of the tag-value field parser: bytes go in one request at a
// time, an in-bench parser model predicts the result of every accepted byte,
// and every result taken from the block is matched against the oldest pending
// prediction field by field
module tb_tag_value_field_parser_top;
  import tvfp_pkg::*;

  typedef logic [7:0] octets_t[$];

  // how the two channel ends hold back traffic
  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tvfp_in_if  in_ch ();
  tvfp_out_if out_ch ();

  tag_value_field_parser_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register values the parser model works with
  tvfp_cfg_t active_cfg = '{
    start_byte:    RST_START_BYTE,
    protocol_byte: RST_PROTOCOL_BYTE,
    type_key:      RST_TYPE_KEY,
    max_value_len: RST_MAX_VALUE_LEN
  };

  // parser model state
  logic [2:0]  rx_phase     = PH_HUNT;
  logic [15:0] field_key    = '0;
  logic [15:0] msg_type_reg = '0;
  logic        type_seen    = 1'b0;
  logic [7:0]  value_count  = '0;
  logic [15:0] type_chars   = '0;

  // predicted parse results not yet seen on the output
  tvfp_res_t   results_due[$];

  int unsigned parsed_bytes  = 0;  // accepted bytes that were not hunt noise
  int unsigned mismatches    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // parser model
  // ---------------------------------------------------------------------------

  // msg_type only shows a type once the type field has closed
  function automatic tvfp_res_t build_result(input logic [2:0] kind_v,
                                             input logic [15:0] key_v,
                                             input logic [7:0] data_v,
                                             input logic [7:0] len_v);
    tvfp_res_t r;
    r.kind      = kind_v;
    r.key       = key_v;
    r.msg_type  = type_seen ? msg_type_reg : 16'h0000;
    r.data      = data_v;
    r.value_len = len_v;
    return r;
  endfunction

  // shared by end-of-message and every error: forget the message, hunt again
  function automatic void close_message();
    type_seen    = 1'b0;
    msg_type_reg = '0;
    field_key    = '0;
    value_count  = '0;
    rx_phase     = PH_HUNT;
  endfunction

  function automatic tvfp_res_t abort_message();
    tvfp_res_t r;
    r = build_result(KIND_ERROR, field_key, 8'h00, value_count);
    close_message();
    return r;
  endfunction

  // advance the model by one byte; returns 1 when the byte yields a result
  function automatic bit parse_byte(input logic [7:0] b, output tvfp_res_t r);
    r = '0;
    case (rx_phase)
      PH_PROTO: begin
        if (b != active_cfg.protocol_byte) begin
          r = abort_message();
          return 1'b1;
        end
        rx_phase = PH_KEY_HI;
      end
      PH_KEY_HI: begin
        // '~' where a key would start closes the message
        if (b == CH_END) begin
          r = build_result(KIND_END, 16'h0000, 8'h00, 8'h00);
          close_message();
          return 1'b1;
        end
        field_key = {b, 8'h00};
        rx_phase  = PH_KEY_LO;
      end
      PH_KEY_LO: begin
        field_key[7:0] = b;
        rx_phase       = PH_WAIT_EQ;
      end
      PH_WAIT_EQ: begin
        if (b != CH_EQ) begin
          r = abort_message();
          return 1'b1;
        end
        value_count = '0;
        type_chars  = '0;
        rx_phase    = PH_VALUE;
      end
      PH_VALUE: begin
        if (b == CH_BAR) begin
          // a message must open with its type field
          if (!type_seen && field_key != active_cfg.type_key) begin
            r = abort_message();
            return 1'b1;
          end
          if (field_key == active_cfg.type_key) begin
            msg_type_reg = type_chars;
            type_seen    = 1'b1;
            r = build_result(KIND_NEW_MSG, field_key, 8'h00, value_count);
          end else begin
            r = build_result(KIND_FIELD, field_key, 8'h00, value_count);
          end
          value_count = '0;
          rx_phase    = PH_KEY_HI;
          return 1'b1;
        end
        if (value_count >= active_cfg.max_value_len) begin
          r = abort_message();
          return 1'b1;
        end
        // first two value characters make up the type
        if (value_count == 8'd0) begin
          type_chars = {b, 8'h00};
        end else if (value_count == 8'd1) begin
          type_chars[7:0] = b;
        end
        value_count++;
        r = build_result(KIND_CHAR, field_key, b, value_count);
        return 1'b1;
      end
      default: begin
        if (b == active_cfg.start_byte) begin
          field_key    = '0;
          msg_type_reg = '0;
          type_seen    = 1'b0;
          value_count  = '0;
          rx_phase     = PH_PROTO;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // prediction and checking
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  // both channels are sampled at the clock edge; the byte taken at this edge
  // cannot have its result out at the same edge, so predicting first is safe
  always @(posedge clk) begin : scoreboard
    tvfp_res_t due;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (rx_phase != PH_HUNT || in_ch.rx_byte == active_cfg.start_byte) begin
          parsed_bytes++;
        end
        if (parse_byte(in_ch.rx_byte, due)) begin
          results_due.push_back(due);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          $display("%0t: result with none pending, kind %0d key %0h data %0h", $time,
                   out_ch.kind, out_ch.key, out_ch.data);
        end else begin
          due = results_due.pop_front();
          compare_field("kind", 16'(due.kind), 16'(out_ch.kind));
          compare_field("key", due.key, out_ch.key);
          compare_field("msg_type", due.msg_type, out_ch.msg_type);
          compare_field("data", 16'(due.data), 16'(out_ch.data));
          compare_field("value_len", 16'(due.value_len), 16'(out_ch.value_len));
        end
      end
    end
    // receiver back-pressure, redrawn every cycle
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_idle_pct = 47;
        stall_pct     = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        stall_pct     = 47;
      end
      IDLE_BOTH: begin
        send_idle_pct = 9;
        stall_pct     = 9;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  // one byte request; valid stays high afterwards so back-to-back bytes
  // never see valid dropped and raised in the same step
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_octets(input octets_t seq);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // sender goes quiet until every predicted result is out, then lets the
  // two-stage pipe flush bytes that produce no result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // writes every register; only called with the parser idle
  task automatic set_config(input logic [7:0] sb, input logic [7:0] pb,
                            input logic [15:0] tk, input logic [7:0] ml);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_START_BYTE;
    cfg_data  <= {8'h00, sb};
    @(posedge clk);
    cfg_index <= CFG_PROTOCOL_BYTE;
    cfg_data  <= {8'h00, pb};
    @(posedge clk);
    cfg_index <= CFG_TYPE_KEY;
    cfg_data  <= tk;
    @(posedge clk);
    cfg_index <= CFG_MAX_VALUE_LEN;
    cfg_data  <= {8'h00, ml};
    @(posedge clk);
    cfg_we <= 1'b0;
    active_cfg = '{start_byte: sb, protocol_byte: pb, type_key: tk, max_value_len: ml};
  endtask

  // ---------------------------------------------------------------------------
  // random message building blocks
  // ---------------------------------------------------------------------------

  // key whose first byte is not the end mark
  function automatic logic [15:0] random_key();
    logic [15:0] k;
    do k = 16'($urandom_range(16'hFFFF)); while (k[15:8] == CH_END);
    return k;
  endfunction

  // mostly short values, now and then right at the length limit
  function automatic int unsigned pick_len();
    int unsigned lim;
    lim = (active_cfg.max_value_len < 6) ? active_cfg.max_value_len : 6;
    if (active_cfg.max_value_len <= 64 && $urandom_range(9) == 0) begin
      return active_cfg.max_value_len;
    end
    return $urandom_range(lim);
  endfunction

  task automatic send_value(input int unsigned len);
    logic [7:0] c;
    repeat (len) begin
      do c = 8'($urandom_range(255)); while (c == CH_BAR);
      send_byte(c);
    end
  endtask

  task automatic send_field(input logic [15:0] k, input int unsigned len);
    send_byte(k[15:8]);
    send_byte(k[7:0]);
    send_byte(CH_EQ);
    send_value(len);
    send_byte(CH_BAR);
  endtask

  task automatic send_header();
    send_byte(active_cfg.start_byte);
    send_byte(active_cfg.protocol_byte);
  endtask

  // mostly well-formed messages with random content, the rest noise and
  // messages broken at each step of the framing
  task automatic send_message();
    int unsigned pick;
    logic [7:0]  b;
    logic [15:0] k;
    pick = $urandom_range(99);
    if (pick < 75) begin
      send_header();
      send_field(active_cfg.type_key, pick_len());
      repeat ($urandom_range(4)) begin
        // now and then a repeated type field
        k = ($urandom_range(9) == 0) ? active_cfg.type_key : random_key();
        send_field(k, pick_len());
      end
      // a few messages are left open and run into the next one
      if ($urandom_range(9) != 0) send_byte(CH_END);
    end else if (pick < 80) begin
      repeat ($urandom_range(6, 1)) send_byte(8'($urandom_range(255)));
    end else if (pick < 85) begin
      // wrong protocol byte
      send_byte(active_cfg.start_byte);
      do b = 8'($urandom_range(255)); while (b == active_cfg.protocol_byte);
      send_byte(b);
    end else if (pick < 90) begin
      // key not followed by '='
      send_header();
      k = random_key();
      send_byte(k[15:8]);
      send_byte(k[7:0]);
      do b = 8'($urandom_range(255)); while (b == CH_EQ);
      send_byte(b);
    end else if (pick < 95) begin
      // value one past the limit, only where that stays cheap
      send_header();
      if (active_cfg.max_value_len <= 64) begin
        send_byte(active_cfg.type_key[15:8]);
        send_byte(active_cfg.type_key[7:0]);
        send_byte(CH_EQ);
        send_value(active_cfg.max_value_len + 1);
      end else begin
        send_field(active_cfg.type_key, pick_len());
      end
    end else begin
      // first field is not the type field
      send_header();
      do k = random_key(); while (k == active_cfg.type_key);
      send_field(k, pick_len());
    end
  endtask

  task automatic run_traffic_phase(input logic [7:0] sb, input logic [7:0] pb,
                                   input logic [15:0] tk, input logic [7:0] ml,
                                   input int unsigned target);
    int unsigned base;
    bit          paused;
    wait_drained();
    set_config(sb, pb, tk, ml);
    base   = parsed_bytes;
    paused = 1'b0;
    while (parsed_bytes - base < target) begin
      set_idle(idle_mode_t'($urandom_range(3)));
      send_message();
      // one full pause mid-phase: nothing in flight before traffic resumes
      if (!paused && parsed_bytes - base >= target / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: start 01, protocol 01, type key "MD"
  task automatic test_message_flow();
    set_idle(IDLE_NONE);
    set_config(RST_START_BYTE, RST_PROTOCOL_BYTE, RST_TYPE_KEY, RST_MAX_VALUE_LEN);
    send_octets('{
      8'hFF,                                    // hunt noise
      8'h01, 8'h01, CH_END,                     // end mark before any type
      8'h01, 8'h01, "M", "D", CH_EQ, "z", CH_BAR, // one-char type, low byte zero
      "X", "Y", CH_EQ, 8'h00, 8'h01, 8'hFF, CH_BAR, // start byte as plain data
      "M", "D", CH_EQ, CH_BAR,                  // type again, empty value
      CH_END
    });
  endtask

  task automatic test_framing_errors();
    set_idle(IDLE_BOTH);
    send_octets('{
      8'h01, 8'h02,                             // bad protocol byte
      8'h01, 8'h01, "M", "D", "x",              // no '=' after key
      8'h01, 8'h01, "Q", "Q", CH_EQ, "a", CH_BAR  // first field is not the type
    });
  endtask

  // one register extreme: start 00, protocol FF, type key 0000, one char max
  task automatic test_register_extremes();
    wait_drained();
    set_config(8'h00, 8'hFF, 16'h0000, 8'd1);
    set_idle(IDLE_RECEIVER);
    send_octets('{
      8'h00, 8'h00,                             // bad protocol, not a new start
      8'h00, 8'hFF, 8'h00, 8'h00, CH_EQ, "a", "b",  // second char too long
      8'h00, 8'hFF, 8'h00, 8'h00, CH_EQ, "A", CH_BAR, CH_END
    });
  endtask

  task automatic test_random_traffic();
    logic [15:0] tk;
    run_traffic_phase(RST_START_BYTE, RST_PROTOCOL_BYTE, RST_TYPE_KEY,
                      RST_MAX_VALUE_LEN, 250);
    run_traffic_phase(8'hFF, 8'h00, 16'hFFFF, 8'd255, 250);
    run_traffic_phase(8'h00, 8'hFF, 16'h0000, 8'd1, 250);
    do tk = 16'($urandom_range(16'hFFFF)); while (tk[15:8] == CH_END);
    run_traffic_phase(8'($urandom_range(255)), 8'($urandom_range(255)), tk,
                      8'($urandom_range(12, 1)), 250);
    do tk = 16'($urandom_range(16'hFFFF)); while (tk[15:8] == CH_END);
    run_traffic_phase(8'($urandom_range(255)), 8'($urandom_range(255)), tk,
                      8'($urandom_range(255, 1)), 250);
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_START_BYTE;
    cfg_data      <= '0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_message_flow();
    test_framing_errors();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
